[rtl/itoa_pkg.sv]
// itoa_pkg: shared widths, payload structs, controller/datapath links and digit table
// for the radix integer-to-ascii converter. No dependencies.
package itoa_pkg;

  // value width and derived divider geometry
  localparam int VALUE_BITS  = 32;
  localparam int MAG_W       = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int STEPS       = 8;
  localparam int DIV_CYCLES  = (MAG_W + STEPS - 1) / STEPS;
  localparam int WORK_W      = DIV_CYCLES * STEPS;
  localparam int DIVC_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // digit store geometry
  localparam int DIGIT_DEPTH = 32;
  localparam int DIG_IDX_W   = 5;
  localparam int CNT_W       = 6;

  // codes and characters
  localparam logic [4:0] RADIX_MIN  = 5'd2;
  localparam logic [4:0] RADIX_MAX  = 5'd16;
  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam logic [7:0] ERR_CHAR   = 8'h00;

  typedef struct packed {
    logic [31:0] raw_value;
    logic [4:0]  radix;
    logic        unsigned_mode;
    logic        lower_case;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
    logic       bad_radix;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic rd_issue;
    logic emit_sign;
    logic emit_digit;
    logic emit_err;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic radix_bad;
    logic conv_done;
    logic neg;
    logic ptr_zero;
  } dp_stat_t;

  // digit value to ascii character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'd0, d};
    end else if (lower) begin
      c = 8'h61 + {4'd0, d} - 8'd10;
    end else begin
      c = 8'h41 + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

[rtl/radix_integer_to_ascii_top.sv]
// radix_integer_to_ascii_top: integer to ascii string converter, top level
// depends on itoa_pkg, itoa_ctrl and itoa_dp
//
//   channel  ports                     handshake
//   -------  ------------------------  ------------------------------------
//   input    start, busy, in_item      transaction taken when start && !busy
//   result   out_valid, out_item       one-cycle strobe, always taken
//
// a bad radix gives one error transaction in the cycle after it is taken; busy stays low.
// a valid item is divided by the radix once per digit (the divider steps at 8 quotient bits
// a cycle, then a store state writes the digit), then each character is read from the single
// digit-store read port and emitted, after a leading minus sign if the value is negative.
// rst_n is synchronous and returns the block to idle with no result pending.
// results cannot be stalled; busy holds off new transactions until the last one.
module radix_integer_to_ascii_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  itoa_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output itoa_pkg::out_item_t  out_item
);
  import itoa_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencing
  itoa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // divider, digit store and output register
  itoa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[rtl/itoa_ctrl.sv]
// itoa_ctrl: sequencing state machine for the converter
// depends on itoa_pkg (command and status structs, divider geometry)
module itoa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  itoa_pkg::dp_stat_t stat,
  output itoa_pkg::ctl_cmd_t cmd
);
  import itoa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STORE,
    S_SIGN,
    S_READ,
    S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [DIVC_W-1:0]  divc_r, divc_nxt;
  logic               busy_r;

  localparam logic [DIVC_W-1:0] DIVC_LAST = DIVC_W'(DIV_CYCLES - 1);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    divc_nxt  = divc_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        divc_nxt = '0;
        if (start) begin
          if (stat.radix_bad) begin
            cmd.emit_err = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (divc_r == DIVC_LAST) begin
          divc_nxt  = '0;
          state_nxt = S_STORE;
        end else begin
          divc_nxt = divc_r + 1'b1;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (stat.conv_done) begin
          state_nxt = stat.neg ? S_SIGN : S_READ;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_nxt     = S_READ;
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_digit = 1'b1;
        state_nxt      = stat.ptr_zero ? S_IDLE : S_READ;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      divc_r  <= '0;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      divc_r  <= divc_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

[rtl/itoa_dp.sv]
// itoa_dp: magnitude register, radix divider, digit store and output register
// depends on itoa_pkg (payload structs, command/status structs, digit table)
module itoa_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  itoa_pkg::in_item_t   in_item,
  input  itoa_pkg::ctl_cmd_t   cmd,
  output itoa_pkg::dp_stat_t   stat,
  output logic                 out_valid,
  output itoa_pkg::out_item_t  out_item
);
  import itoa_pkg::*;

  logic [WORK_W-1:0]    work_r, work_nxt;
  logic [3:0]           rem_r, rem_nxt;
  logic [4:0]           base_r;
  logic                 lower_r;
  logic                 neg_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIG_IDX_W-1:0] rdptr_r;
  logic [3:0]           rd_data_r;
  logic [3:0]           digit_mem [DIGIT_DEPTH];
  logic                 out_valid_r;
  out_item_t            out_item_r, out_item_nxt;

  logic [MAG_W-1:0]     in_val;
  logic                 in_neg;
  logic [MAG_W-1:0]     in_mag;

  // input decode: sign and magnitude
  // a sign bit above the 32 raw value bits is never set
  assign in_val = in_item.raw_value[MAG_W-1:0];
  assign in_neg = !in_item.unsigned_mode && (VALUE_BITS <= 32) && in_val[MAG_W-1];
  assign in_mag = in_neg ? (~in_val + 1'b1) : in_val;

  // status to controller
  assign stat.radix_bad = (in_item.radix < RADIX_MIN) || (in_item.radix > RADIX_MAX);
  assign stat.conv_done = (work_r == '0) || (cnt_r == CNT_W'(DIGIT_DEPTH - 1));
  assign stat.neg       = neg_r;
  assign stat.ptr_zero  = (rdptr_r == '0);

  // restoring divide by radix, STEPS quotient bits per cycle
  always_comb begin
    logic [4:0]        r;
    logic [WORK_W-1:0] m;
    r = {1'b0, rem_r};
    m = work_r;
    for (int i = 0; i < STEPS; i++) begin
      r = {r[3:0], m[WORK_W-1]};
      m = {m[WORK_W-2:0], 1'b0};
      if (r >= base_r) begin
        r    = r - base_r;
        m[0] = 1'b1;
      end
    end
    work_nxt = m;
    rem_nxt  = r[3:0];
  end

  // output transaction select
  always_comb begin
    out_item_nxt = out_item_r;
    if (cmd.emit_err) begin
      out_item_nxt.out_char  = ERR_CHAR;
      out_item_nxt.last_char = 1'b1;
      out_item_nxt.bad_radix = 1'b1;
    end else if (cmd.emit_sign) begin
      out_item_nxt.out_char  = MINUS_CHAR;
      out_item_nxt.last_char = 1'b0;
      out_item_nxt.bad_radix = 1'b0;
    end else if (cmd.emit_digit) begin
      out_item_nxt.out_char  = digit_char(rd_data_r, lower_r);
      out_item_nxt.last_char = (rdptr_r == '0);
      out_item_nxt.bad_radix = 1'b0;
    end
  end

  // conversion state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_r <= '0;
      cnt_r  <= '0;
      neg_r  <= 1'b0;
    end else if (cmd.emit_err) begin
      work_r <= '0;
      cnt_r  <= '0;
      neg_r  <= 1'b0;
    end else if (cmd.load) begin
      work_r <= WORK_W'(in_mag);
      cnt_r  <= '0;
      neg_r  <= in_neg;
    end else if (cmd.div_step) begin
      work_r <= work_nxt;
    end else if (cmd.store) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r  <= in_item.radix;
      lower_r <= in_item.lower_case;
      rem_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
    end else if (cmd.store) begin
      rem_r   <= '0;
      rdptr_r <= cnt_r[DIG_IDX_W-1:0];
    end else if (cmd.emit_digit) begin
      rdptr_r <= rdptr_r - 1'b1;
    end
    out_item_r <= out_item_nxt;
  end

  // digit store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      digit_mem[cnt_r[DIG_IDX_W-1:0]] <= rem_r;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= digit_mem[rdptr_r];
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_err | cmd.emit_sign | cmd.emit_digit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
